// File: rtl/ddwc_pkg.sv
`default_nettype none

package ddwc_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_TRACK_MM  = 2'd0;
    localparam logic [1:0] REG_MAX_WHEEL = 2'd1;
    localparam logic [1:0] REG_MAX_TURN  = 2'd2;
    localparam logic [1:0] REG_GAIN      = 2'd3;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Register reset values.
    localparam logic [11:0] RST_TRACK_MM  = 12'd775;
    localparam logic [14:0] RST_MAX_WHEEL = 15'd500;
    localparam logic [14:0] RST_MAX_TURN  = 15'd400;
    localparam logic [15:0] RST_GAIN      = 16'hF05B;

    // The half track term divides track * w by 2000. The product is first
    // shifted down by four, then divided by 125 through a multiplication by
    // ceil(2^30 / 125) and a shift by 30, which is exact for 23-bit operands.
    localparam logic [23:0] TRACK_RECIP = 24'd8589935;

    // Quotient widths of the divider pipelines.
    localparam int TURN_QUO_W  = 16;
    localparam int WHEEL_QUO_W = 16;

    // Cycles from an accepted command to its result strobe.
    localparam int LATENCY = TURN_QUO_W + WHEEL_QUO_W + 7;

    typedef struct packed {
        logic signed [15:0] lin_speed;
        logic signed [15:0] turn_rate;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] right_cmd;
        logic signed [15:0] left_cmd;
        logic               turn_limited;
        logic               wheel_limited;
    } result_t;

    // Side data carried alongside the turn limit divider.
    typedef struct packed {
        logic        turn_hit;
        logic        v_neg;
        logic        w_neg;
        logic [15:0] v;
        logic [15:0] w_abs;
    } turn_side_t;

    // Side data carried alongside the half track multiplication.
    typedef struct packed {
        logic        turn_hit;
        logic        w_neg;
        logic [15:0] v;
    } track_side_t;

    // Side data carried alongside the right wheel divider.
    typedef struct packed {
        logic        turn_hit;
        logic        wheel_hit;
        logic        r_neg;
        logic [15:0] r;
    } wheel_side_t;

    // Side data carried alongside the left wheel divider.
    typedef struct packed {
        logic        l_neg;
        logic [15:0] l;
    } left_side_t;

endpackage

`default_nettype wire

// File: rtl/ddwc_div.sv
`default_nettype none

// Pipelined unsigned restoring divider, one quotient bit per stage.
// The caller guarantees that the quotient fits in QUO_W bits whenever the
// result is used, so the remainder starts from the dividend's upper bits.
module ddwc_div #(
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 17,
    parameter int QUO_W  = 16,
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    input  wire logic [SIDE_W-1:0] side,
    output logic                   out_valid,
    output logic [QUO_W-1:0]       quo,
    output logic [SIDE_W-1:0]      out_side
);

    logic [QUO_W-1:0]  vld_reg;
    logic [DEN_W-1:0]  rem_reg  [QUO_W];
    logic [QUO_W-1:0]  lo_reg   [QUO_W];
    logic [DEN_W-1:0]  den_reg  [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];

    for (genvar i = 0; i < QUO_W; i++) begin : g_stage
        logic             vld_prev;
        logic [DEN_W-1:0] rem_prev;
        logic [QUO_W-1:0] lo_prev;
        logic [DEN_W-1:0] den_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (i == 0) begin : g_first
            assign vld_prev  = in_valid;
            assign rem_prev  = DEN_W'(num[NUM_W-1:QUO_W]);
            assign lo_prev   = num[QUO_W-1:0];
            assign den_prev  = den;
            assign side_prev = side;
        end else begin : g_next
            assign vld_prev  = vld_reg[i-1];
            assign rem_prev  = rem_reg[i-1];
            assign lo_prev   = lo_reg[i-1];
            assign den_prev  = den_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        // Bring in the next dividend bit and try a subtraction.
        assign trial = {rem_prev, lo_prev[QUO_W-1]};
        assign diff  = trial - {1'b0, den_prev};
        assign ge    = (trial >= {1'b0, den_prev});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else
            begin
                vld_reg[i] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            lo_reg[i]   <= {lo_prev[QUO_W-2:0], ge};
            den_reg[i]  <= den_prev;
            side_reg[i] <= side_prev;
        end
    end

    assign out_valid = vld_reg[QUO_W-1];
    assign quo       = lo_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

`default_nettype wire

// File: rtl/diff_drive_wheel_command.sv
// Differential drive wheel command: turns a body command (forward speed and
// turn rate) into saturated right and left motor register values. A command
// is taken on any cycle where start is high; busy is always low, so one
// command may enter every cycle. Each result appears for one cycle with done
// high, in command order; the receiver cannot stall the block, so results
// must be captured when done is high. The pipeline is made of two
// bit-per-stage divider pipelines of 16 stages each (the turn limit, then the
// right and left wheel limit side by side) plus seven register stages; the
// half-track division by 2000 is done as a shift and a reciprocal
// multiplication. Configuration registers should only be written
// while no command is in flight.
`default_nettype none

module diff_drive_wheel_command (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire ddwc_pkg::cmd_t                      cmd,
    output logic                                     done,
    output ddwc_pkg::result_t                        result,
    input  wire logic                                cfg_wr,
    input  wire logic [ddwc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [ddwc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // Configuration registers.
    logic [11:0] track_mm_reg;
    logic [14:0] max_wheel_reg;
    logic [14:0] max_turn_reg;
    logic [15:0] gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_mm_reg  <= ddwc_pkg::RST_TRACK_MM;
            max_wheel_reg <= ddwc_pkg::RST_MAX_WHEEL;
            max_turn_reg  <= ddwc_pkg::RST_MAX_TURN;
            gain_reg      <= ddwc_pkg::RST_GAIN;
        end
        else if (cfg_wr)
        begin
            case (cfg_addr)
                ddwc_pkg::REG_TRACK_MM:  track_mm_reg  <= cfg_wdata[11:0];
                ddwc_pkg::REG_MAX_WHEEL: max_wheel_reg <= cfg_wdata[14:0];
                ddwc_pkg::REG_MAX_TURN:  max_turn_reg  <= cfg_wdata[14:0];
                ddwc_pkg::REG_GAIN:      gain_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage A: magnitudes, turn limit test and the turn limit dividend.
    logic [16:0] v_ext, w_ext, v_abs, w_abs;
    logic        a_vld_reg;
    logic [31:0] a_num_reg;
    logic [16:0] a_aw_reg;
    ddwc_pkg::turn_side_t a_side_reg;

    assign v_ext = {cmd.lin_speed[15], cmd.lin_speed};
    assign w_ext = {cmd.turn_rate[15], cmd.turn_rate};
    assign v_abs = cmd.lin_speed[15] ? 17'd0 - v_ext : v_ext;
    assign w_abs = cmd.turn_rate[15] ? 17'd0 - w_ext : w_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        a_num_reg           <= 32'(v_abs) * 32'(max_turn_reg);
        a_aw_reg            <= w_abs;
        a_side_reg.turn_hit <= (w_abs > {2'b00, max_turn_reg});
        a_side_reg.v_neg    <= cmd.lin_speed[15];
        a_side_reg.w_neg    <= cmd.turn_rate[15];
        a_side_reg.v        <= cmd.lin_speed;
        a_side_reg.w_abs    <= w_abs[15:0];
    end

    // Turn limit division: |v| * max_turn / |w|.
    logic                 d1_vld;
    logic [15:0]          d1_quo;
    ddwc_pkg::turn_side_t d1_side;

    ddwc_div #(
        .NUM_W  (32),
        .DEN_W  (17),
        .QUO_W  (ddwc_pkg::TURN_QUO_W),
        .SIDE_W ($bits(ddwc_pkg::turn_side_t))
    ) u_div_turn (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_vld_reg),
        .num       (a_num_reg),
        .den       (a_aw_reg),
        .side      (a_side_reg),
        .out_valid (d1_vld),
        .quo       (d1_quo),
        .out_side  (d1_side)
    );

    // Stage B: limited speeds and the half track product, scaled down by 16.
    logic                  b_vld_reg;
    logic [22:0]           b_y_reg;
    ddwc_pkg::track_side_t b_side_reg;
    logic [15:0]           w1_abs;
    logic [15:0]           v1;
    logic [26:0]           b_prod;

    assign w1_abs = d1_side.turn_hit ? {1'b0, max_turn_reg} : d1_side.w_abs;
    assign v1 = d1_side.turn_hit ? (d1_side.v_neg ? 16'd0 - d1_quo : d1_quo) : d1_side.v;
    assign b_prod = 27'(w1_abs) * 27'(track_mm_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else
        begin
            b_vld_reg <= d1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        b_y_reg             <= b_prod[26:4];
        b_side_reg.turn_hit <= d1_side.turn_hit;
        b_side_reg.w_neg    <= d1_side.w_neg;
        b_side_reg.v        <= v1;
    end

    // Stage C: divide by 125 through the reciprocal multiplication.
    logic                  c_vld_reg;
    logic [46:0]           c_prod_reg;
    ddwc_pkg::track_side_t c_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else
        begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_prod_reg <= 47'(b_y_reg) * 47'(ddwc_pkg::TRACK_RECIP);
        c_side_reg <= b_side_reg;
    end

    logic                  d2_vld;
    logic [16:0]           d2_quo;
    ddwc_pkg::track_side_t d2_side;

    assign d2_vld  = c_vld_reg;
    assign d2_quo  = c_prod_reg[46:30];
    assign d2_side = c_side_reg;

    // Stage D: right and left wheel speeds.
    logic        dd_vld_reg;
    logic [18:0] right_reg, left_reg;
    logic        dd_turn_reg;
    logic [18:0] d_term, v1_ext;

    assign d_term = d2_side.w_neg ? 19'd0 - 19'(d2_quo) : 19'(d2_quo);
    assign v1_ext = {{3{d2_side.v[15]}}, d2_side.v};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dd_vld_reg <= 1'b0;
        end
        else
        begin
            dd_vld_reg <= d2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        right_reg   <= v1_ext + d_term;
        left_reg    <= v1_ext - d_term;
        dd_turn_reg <= d2_side.turn_hit;
    end

    // Stage E: wheel limit test and the wheel limit dividends.
    logic [18:0] r_neg_val, l_neg_val;
    logic [16:0] ar, al;
    logic        e_vld_reg;
    logic [31:0] e_num_r_reg, e_num_l_reg;
    logic [16:0] e_m_reg;
    ddwc_pkg::wheel_side_t e_side_reg;
    ddwc_pkg::left_side_t  e_lside_reg;

    assign r_neg_val = 19'd0 - right_reg;
    assign l_neg_val = 19'd0 - left_reg;
    assign ar = right_reg[18] ? r_neg_val[16:0] : right_reg[16:0];
    assign al = left_reg[18] ? l_neg_val[16:0] : left_reg[16:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
        end
        else
        begin
            e_vld_reg <= dd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e_num_r_reg          <= 32'(ar) * 32'(max_wheel_reg);
        e_num_l_reg          <= 32'(al) * 32'(max_wheel_reg);
        e_m_reg              <= (ar > al) ? ar : al;
        e_side_reg.turn_hit  <= dd_turn_reg;
        e_side_reg.wheel_hit <= (ar > {2'b00, max_wheel_reg}) || (al > {2'b00, max_wheel_reg});
        e_side_reg.r_neg     <= right_reg[18];
        e_side_reg.r         <= right_reg[15:0];
        e_lside_reg.l_neg    <= left_reg[18];
        e_lside_reg.l        <= left_reg[15:0];
    end

    // Wheel limit divisions, right and left in parallel.
    logic                  d3_vld, d4_vld;
    logic [15:0]           d3_quo, d4_quo;
    ddwc_pkg::wheel_side_t d3_side;
    ddwc_pkg::left_side_t  d4_side;

    ddwc_div #(
        .NUM_W  (32),
        .DEN_W  (17),
        .QUO_W  (ddwc_pkg::WHEEL_QUO_W),
        .SIDE_W ($bits(ddwc_pkg::wheel_side_t))
    ) u_div_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (e_vld_reg),
        .num       (e_num_r_reg),
        .den       (e_m_reg),
        .side      (e_side_reg),
        .out_valid (d3_vld),
        .quo       (d3_quo),
        .out_side  (d3_side)
    );

    ddwc_div #(
        .NUM_W  (32),
        .DEN_W  (17),
        .QUO_W  (ddwc_pkg::WHEEL_QUO_W),
        .SIDE_W ($bits(ddwc_pkg::left_side_t))
    ) u_div_left (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (e_vld_reg),
        .num       (e_num_l_reg),
        .den       (e_m_reg),
        .side      (e_lside_reg),
        .out_valid (d4_vld),
        .quo       (d4_quo),
        .out_side  (d4_side)
    );

    // Stage F: wheel magnitudes times the gain magnitude.
    logic [16:0] gain_ext, gain_abs;
    logic [15:0] r_abs16, l_abs16;
    logic [14:0] mag_r, mag_l;
    logic        f_vld_reg;
    logic [31:0] f_prod_r_reg, f_prod_l_reg;
    logic        f_neg_r_reg, f_neg_l_reg;
    logic        f_turn_reg, f_wheel_reg;

    assign gain_ext = {gain_reg[15], gain_reg};
    assign gain_abs = gain_reg[15] ? 17'd0 - gain_ext : gain_ext;
    assign r_abs16  = d3_side.r_neg ? 16'd0 - d3_side.r : d3_side.r;
    assign l_abs16  = d4_side.l_neg ? 16'd0 - d4_side.l : d4_side.l;
    assign mag_r    = d3_side.wheel_hit ? d3_quo[14:0] : r_abs16[14:0];
    assign mag_l    = d3_side.wheel_hit ? d4_quo[14:0] : l_abs16[14:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else
        begin
            f_vld_reg <= d3_vld & d4_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        f_prod_r_reg <= 32'(mag_r) * 32'(gain_abs);
        f_prod_l_reg <= 32'(mag_l) * 32'(gain_abs);
        f_neg_r_reg  <= d3_side.r_neg ^ gain_reg[15];
        f_neg_l_reg  <= d4_side.l_neg ^ gain_reg[15];
        f_turn_reg   <= d3_side.turn_hit;
        f_wheel_reg  <= d3_side.wheel_hit;
    end

    // Stage G: drop the Q8.8 fraction, restore the sign and saturate.
    function automatic logic [15:0] sat_out(input logic [31:0] prod, input logic neg);
        logic [23:0] m;
        m = prod[31:8];
        if (neg)
        begin
            sat_out = (m > 24'd32768) ? 16'h8000 : 16'(24'd0 - m);
        end
        else
        begin
            sat_out = (m > 24'd32767) ? 16'h7FFF : m[15:0];
        end
    endfunction

    logic              done_reg;
    ddwc_pkg::result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.right_cmd     <= sat_out(f_prod_r_reg, f_neg_r_reg);
        result_reg.left_cmd      <= sat_out(f_prod_l_reg, f_neg_l_reg);
        result_reg.turn_limited  <= f_turn_reg;
        result_reg.wheel_limited <= f_wheel_reg;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// File: rtl/ddwc_checker.sv
`default_nettype none

// Port-level checks on the wheel command block.
module ddwc_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);

    // The block never refuses a command.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // Every accepted command yields a result beat after the fixed latency.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(ddwc_pkg::LATENCY) done)
        else $error("result beat missing");

    // No result beat without a command accepted the latency earlier.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, ddwc_pkg::LATENCY))
        else $error("unexpected result beat");

endmodule

bind diff_drive_wheel_command ddwc_checker u_ddwc_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

`default_nettype wire
